// File: hdl/paged_slot_bitmap_allocator_top_macros.svh
// Assertion macros used by the checker file of the slot allocator.
`ifndef PAGED_SLOT_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`define PAGED_SLOT_BITMAP_ALLOCATOR_TOP_MACROS_SVH

// Checks that cond holds in the cycle after trig.
`define PSBA_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("allocator assertion failed: next-cycle check");

// Checks that cond holds in the same cycle as trig.
`define PSBA_ASSERT_NOW(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error("allocator assertion failed: same-cycle check");

`endif

// File: hdl/psba_pkg.sv
// ---------------------------------------------------------------------------
// Slot allocator package
// Widths, request and response types, and the control structs that run
// between the page cells and the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psba_pkg;

  localparam int NumPages = 8;
  localparam int PageW    = 3;
  localparam int NumSlots = 64;
  localparam int SlotW    = 6;
  localparam int CountW   = 7;
  localparam int RankW    = 3;

  typedef enum logic {
    CmdAlloc = 1'b0,
    CmdFree  = 1'b1
  } psba_cmd_code_e;

  typedef enum logic [1:0] {
    StDone    = 2'd0,
    StFull    = 2'd1,
    StIgnored = 2'd2
  } psba_status_e;

  typedef enum logic [2:0] {
    OpNone    = 3'd0,
    OpTake    = 3'd1,
    OpOpen    = 3'd2,
    OpRelease = 3'd3,
    OpClose   = 3'd4
  } psba_op_e;

  typedef struct packed {
    logic             command;
    logic [PageW-1:0] page_index;
    logic [SlotW-1:0] slot_index;
  } psba_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [PageW-1:0] given_page;
    logic [SlotW-1:0] given_slot;
    logic             page_opened;
    logic             page_closed;
  } psba_rsp_t;

  // Update broadcast from the top level to every cell.
  typedef struct packed {
    psba_op_e         op;
    logic [PageW-1:0] page;
    logic [SlotW-1:0] slot;
    logic [RankW-1:0] gone_rank;
  } psba_cmd_t;

  // Best open page with room found so far along the chain.
  typedef struct packed {
    logic             found;
    logic [RankW-1:0] rank;
    logic [PageW-1:0] page;
    logic [SlotW-1:0] slot;
  } psba_srch_t;

  // Lowest closed page found so far along the chain.
  typedef struct packed {
    logic             found;
    logic [PageW-1:0] page;
  } psba_vac_t;

  typedef struct packed {
    logic              open;
    logic [CountW-1:0] used;
    logic [RankW-1:0]  rank;
  } psba_cell_st_t;

endpackage

`default_nettype wire

// File: hdl/psba_cell.sv
// ---------------------------------------------------------------------------
// Page cell
// Holds one page entry and takes part in the newest-first search chain and
// the lowest-closed-page chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psba_cell
  import psba_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [PageW-1:0]    idx_i,
  input  wire logic [NumSlots-1:0] slot_mask_i,
  input  wire logic [CountW-1:0]   slot_cnt_i,
  input  wire psba_cmd_t           cmd_i,
  input  wire psba_srch_t          srch_i,
  output psba_srch_t               srch_o,
  input  wire psba_vac_t           vac_i,
  output psba_vac_t                vac_o,
  output psba_cell_st_t            stat_o
);

  logic                open_q, open_d;
  logic [CountW-1:0]   used_q, used_d;
  logic [NumSlots-1:0] fmap_q, fmap_d;
  logic [RankW-1:0]    rank_q, rank_d;
  logic                room_q, room_d;
  logic [SlotW-1:0]    slot_q, slot_d;

  logic [NumSlots-1:0] avail;
  logic [NumSlots-1:0] lowest;
  logic                mine;

  // Lowest free slot: isolate the lowest set bit, then encode it.
  always_comb begin
    avail  = fmap_q & slot_mask_i;
    lowest = avail & (~avail + NumSlots'(1));
    slot_d = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (lowest[i]) begin
        slot_d = slot_d | SlotW'(i);
      end
    end
    room_d = open_q && (used_q < slot_cnt_i) && (|avail);
  end

  // The room flag and slot are sampled every cycle, so they match the state
  // at the edge where a request is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_q <= 1'b0;
    end else begin
      room_q <= room_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  always_comb begin
    srch_o = srch_i;
    if (room_q && (!srch_i.found || (rank_q < srch_i.rank))) begin
      srch_o.found = 1'b1;
      srch_o.rank  = rank_q;
      srch_o.page  = idx_i;
      srch_o.slot  = slot_q;
    end
    vac_o = vac_i;
    if (!vac_i.found && !open_q) begin
      vac_o.found = 1'b1;
      vac_o.page  = idx_i;
    end
  end

  assign stat_o = '{open: open_q, used: used_q, rank: rank_q};
  assign mine   = (cmd_i.page == idx_i);

  always_comb begin
    open_d = open_q;
    used_d = used_q;
    fmap_d = fmap_q;
    rank_d = rank_q;
    case (cmd_i.op)
      OpTake: begin
        if (mine) begin
          fmap_d[cmd_i.slot] = 1'b0;
          used_d             = used_q + CountW'(1);
        end
      end
      OpOpen: begin
        if (mine) begin
          open_d = 1'b1;
          used_d = CountW'(1);
          fmap_d = ~NumSlots'(1);
          rank_d = '0;
        end else if (open_q) begin
          rank_d = rank_q + RankW'(1);
        end
      end
      OpRelease: begin
        if (mine) begin
          fmap_d[cmd_i.slot] = 1'b1;
          used_d             = used_q - CountW'(1);
        end
      end
      OpClose: begin
        if (mine) begin
          open_d = 1'b0;
          used_d = '0;
          fmap_d = '1;
          rank_d = '0;
        end else if (open_q && (rank_q > cmd_i.gone_rank)) begin
          rank_d = rank_q - RankW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      used_q <= '0;
      fmap_q <= '1;
      rank_q <= '0;
    end else begin
      open_q <= open_d;
      used_q <= used_d;
      fmap_q <= fmap_d;
      rank_q <= rank_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/paged_slot_bitmap_allocator_top.sv
// ---------------------------------------------------------------------------
// Paged slot bitmap allocator
// Allocates and frees slots grouped into page entries, searching open pages
// newest first through a chain of page cells.
// ---------------------------------------------------------------------------
//   Channel   Signals                          Direction
//   in        in_valid_i, in_stall_o, in_req_i   request in
//   out       out_valid_o, out_stall_i, out_rsp_o response out
//   cfg       cfg_we_i, cfg_wdata_i              slots_per_page write
//
// A request is handled in steps: first the accept edge samples every cell's room
// flag and lowest free slot, then a later edge runs the search chain across the
// cells and applies the update. That second step waits while a finished
// response is stalled. Reset closes every page and sets slots_per_page to 64;
// no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module paged_slot_bitmap_allocator_top
  import psba_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire psba_req_t  in_req_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output psba_rsp_t       out_rsp_o,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i
);

  typedef enum logic [1:0] {
    SIdle = 2'b01,
    SExec = 2'b10
  } psba_state_e;

  psba_state_e state_q, state_d;
  psba_req_t   req_q;
  logic [6:0]  spp_q;
  logic        out_valid_q, out_valid_d;
  psba_rsp_t   out_q, out_d;

  logic [CountW-1:0]   slot_cnt;
  logic [NumSlots-1:0] slot_mask;
  psba_cmd_t           cmd;
  psba_srch_t          srch [NumPages+1];
  psba_vac_t           vac  [NumPages+1];
  psba_cell_st_t       stat [NumPages];
  psba_cell_st_t       sel;
  logic                fire;
  logic                accept;

  always_comb begin
    if (spp_q == 7'd0) begin
      slot_cnt = CountW'(1);
    end else if (spp_q > 7'(NumSlots)) begin
      slot_cnt = CountW'(NumSlots);
    end else begin
      slot_cnt = spp_q;
    end
    for (int i = 0; i < NumSlots; i++) begin
      slot_mask[i] = (CountW'(i) < slot_cnt);
    end
  end

  assign srch[0] = '0;
  assign vac[0]  = '0;

  for (genvar g = 0; g < NumPages; g++) begin : gen_cell
    psba_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (PageW'(g)),
      .slot_mask_i (slot_mask),
      .slot_cnt_i  (slot_cnt),
      .cmd_i       (cmd),
      .srch_i      (srch[g]),
      .srch_o      (srch[g+1]),
      .vac_i       (vac[g]),
      .vac_o       (vac[g+1]),
      .stat_o      (stat[g])
    );
  end

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != SIdle);
  assign fire       = (state_q == SExec) && (!out_valid_q || !out_stall_i);
  assign sel        = stat[req_q.page_index];

  always_comb begin
    cmd   = '{op: OpNone, page: '0, slot: '0, gone_rank: '0};
    out_d = out_q;
    if (fire) begin
      out_d = '0;
      if (req_q.command == CmdAlloc) begin
        if (srch[NumPages].found) begin
          cmd.op   = OpTake;
          cmd.page = srch[NumPages].page;
          cmd.slot = srch[NumPages].slot;
          out_d.given_page = srch[NumPages].page;
          out_d.given_slot = srch[NumPages].slot;
        end else if (vac[NumPages].found) begin
          cmd.op   = OpOpen;
          cmd.page = vac[NumPages].page;
          out_d.given_page  = vac[NumPages].page;
          out_d.page_opened = 1'b1;
        end else begin
          out_d.status = StFull;
        end
      end else begin
        if (!sel.open || ({1'b0, req_q.slot_index} >= slot_cnt)) begin
          out_d.status = StIgnored;
        end else if (sel.used <= CountW'(1)) begin
          cmd.op        = OpClose;
          cmd.page      = req_q.page_index;
          cmd.gone_rank = sel.rank;
          out_d.page_closed = 1'b1;
        end else begin
          cmd.op   = OpRelease;
          cmd.page = req_q.page_index;
          cmd.slot = req_q.slot_index;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: begin
        if (accept) begin
          state_d = SExec;
        end
      end
      SExec: begin
        if (fire) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
      spp_q       <= 7'(NumSlots);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        spp_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

// File: hdl/psba_checker.sv
// ---------------------------------------------------------------------------
// Slot allocator port checker
// Watches the top-level ports for handshake and sequencing errors.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "paged_slot_bitmap_allocator_top_macros.svh"

module psba_checker
  import psba_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire psba_rsp_t  out_rsp_o
);

  // A taken request makes the block busy, so in_stall_o is high once the request is registered.
  `PSBA_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o)

  // A stalled response stays valid and unchanged.
  `PSBA_ASSERT_NEXT(a_rsp_hold, out_valid_o && out_stall_i,
                    out_valid_o && $stable(out_rsp_o))

  // A new response only shows up after the block was working on a request.
  `PSBA_ASSERT_NOW(a_rsp_after_busy, $rose(out_valid_o), $past(in_stall_o))

  // Only a successful allocate opens a page, and never together with a close.
  `PSBA_ASSERT_NOW(a_open_close, out_valid_o && out_rsp_o.page_opened,
                   !out_rsp_o.page_closed && (out_rsp_o.status == StDone) &&
                   (out_rsp_o.given_slot == '0))

endmodule

bind paged_slot_bitmap_allocator_top psba_checker u_psba_checker (.*);

`default_nettype wire

// File: tb/testbench.sv
// ---------------------------------------------------------------------------
// Testbench for the paged slot bitmap allocator
// Drives allocate and free requests with random gaps and output stalls, keeps
// a shadow copy of the page table to predict every response, and compares
// each response field by field. The slot count is changed between phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import psba_pkg::*;

  // Shadow page table: predicts the response of each accepted request.
  class slot_ledger;
    logic [6:0]          slot_count;
    bit                  page_live[NumPages];
    int unsigned         page_used[NumPages];
    logic [NumSlots-1:0] free_bits[NumPages];
    int unsigned         page_rank[NumPages];
    psba_rsp_t           awaited[$];
    int unsigned         errors, n_alloc, n_free, n_full, n_ignored;
    int unsigned         n_opened, n_closed, n_checked, n_settings;

    function void reset_state();
      slot_count = 7'd64;
      foreach (page_live[p]) begin
        page_live[p] = 1'b0;
        page_used[p] = 0;
        free_bits[p] = '1;
        page_rank[p] = 0;
      end
    endfunction

    function void write_count(logic [6:0] value);
      slot_count = value;
      n_settings++;
    endfunction

    // A count of zero behaves as one, and anything above the page size as the page size.
    function int unsigned usable_slots();
      if (slot_count == 7'd0) return 1;
      if (slot_count > NumSlots) return NumSlots;
      return slot_count;
    endfunction

    function logic [NumSlots-1:0] slot_mask();
      int unsigned n;
      n = usable_slots();
      return (n >= NumSlots) ? {NumSlots{1'b1}} : ((64'd1 << n) - 64'd1);
    endfunction

    function void note_request(psba_req_t req);
      psba_rsp_t           want;
      int unsigned         n;
      logic [NumSlots-1:0] avail;
      int                  pg, b, r, gone;
      bit                  done;
      want = '0;
      want.status = StDone;
      n = usable_slots();
      done = 1'b0;
      if (req.command == CmdAlloc) begin
        n_alloc++;
        for (r = 0; r < NumPages && !done; r++) begin
          for (pg = 0; pg < NumPages && !done; pg++) begin
            avail = free_bits[pg] & slot_mask();
            if (page_live[pg] && page_rank[pg] == r && page_used[pg] < n && avail != '0) begin
              b = 0;
              while (!avail[b]) b++;
              free_bits[pg][b] = 1'b0;
              page_used[pg]++;
              want.given_page = PageW'(pg);
              want.given_slot = SlotW'(b);
              done = 1'b1;
            end
          end
        end
        // No open page has room: open the lowest closed entry as the newest page.
        for (pg = 0; pg < NumPages && !done; pg++) begin
          if (!page_live[pg]) begin
            foreach (page_live[q]) if (page_live[q]) page_rank[q]++;
            page_live[pg] = 1'b1;
            page_rank[pg] = 0;
            free_bits[pg] = ~64'd1;
            page_used[pg] = 1;
            want.given_page = PageW'(pg);
            want.page_opened = 1'b1;
            n_opened++;
            done = 1'b1;
          end
        end
        if (!done) begin
          want.status = StFull;
          n_full++;
        end
      end else begin
        n_free++;
        pg = req.page_index;
        b = req.slot_index;
        if (!page_live[pg] || b >= n) begin
          want.status = StIgnored;
          n_ignored++;
        end else if (page_used[pg] <= 1) begin
          gone = page_rank[pg];
          page_live[pg] = 1'b0;
          page_used[pg] = 0;
          free_bits[pg] = '1;
          page_rank[pg] = 0;
          foreach (page_live[q]) if (page_live[q] && page_rank[q] > gone) page_rank[q]--;
          want.page_closed = 1'b1;
          n_closed++;
        end else begin
          page_used[pg]--;
          free_bits[pg][b] = 1'b1;
        end
      end
      awaited.push_back(want);
    endfunction

    function void check_response(psba_rsp_t got);
      psba_rsp_t want;
      if (awaited.size() == 0) begin
        errors++;
        $error("response arrived with no request outstanding");
        return;
      end
      want = awaited.pop_front();
      n_checked++;
      if (got.status !== want.status) begin
        errors++;
        $error("status: expected %0d, got %0d", want.status, got.status);
      end
      if (got.given_page !== want.given_page) begin
        errors++;
        $error("given_page: expected %0d, got %0d", want.given_page, got.given_page);
      end
      if (got.given_slot !== want.given_slot) begin
        errors++;
        $error("given_slot: expected %0d, got %0d", want.given_slot, got.given_slot);
      end
      if (got.page_opened !== want.page_opened) begin
        errors++;
        $error("page_opened: expected %0d, got %0d", want.page_opened, got.page_opened);
      end
      if (got.page_closed !== want.page_closed) begin
        errors++;
        $error("page_closed: expected %0d, got %0d", want.page_closed, got.page_closed);
      end
    endfunction

    // Picks a slot that is currently handed out, so that most frees are legal.
    function bit pick_held(output logic [PageW-1:0] pg, output logic [SlotW-1:0] sl);
      int                  cand[$];
      int                  p, b;
      logic [NumSlots-1:0] held;
      foreach (page_live[q]) begin
        held = ~free_bits[q] & slot_mask();
        if (page_live[q] && held != '0) cand.push_back(q);
      end
      if (cand.size() == 0) return 1'b0;
      p = cand[$urandom_range(0, cand.size() - 1)];
      held = ~free_bits[p] & slot_mask();
      do b = $urandom_range(0, usable_slots() - 1); while (!held[b]);
      pg = PageW'(p);
      sl = SlotW'(b);
      return 1'b1;
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  psba_req_t  in_req_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  psba_rsp_t  out_rsp_o;
  logic       cfg_we_i = 1'b0;
  logic [6:0] cfg_wdata_i = 7'd0;

  slot_ledger ledger;
  bit         steady = 1'b0;
  bit         hold_off_pending = 1'b0;

  paged_slot_bitmap_allocator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) ledger.check_response(out_rsp_o);
      if (in_valid_i && !in_stall_o) ledger.note_request(in_req_i);
    end
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Response side: random stalls, plus one long hold-off when asked for.
  initial begin
    int unsigned stall_len;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        stall_len = 300;
      end else begin
        stall_len = pick_gap();
      end
      if (stall_len != 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat (steady ? 16 : $urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  function automatic psba_req_t make_req(logic cmd, int pg, int sl);
    psba_req_t req;
    req.command = cmd;
    req.page_index = PageW'(pg);
    req.slot_index = SlotW'(sl);
    return req;
  endfunction

  function automatic psba_req_t alloc_req();
    return make_req(CmdAlloc, $urandom_range(0, NumPages - 1), $urandom_range(0, NumSlots - 1));
  endfunction

  task automatic send_request(input psba_req_t req);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Waits until every outstanding request has its response, plus a short tail.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ledger.awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_slot_count(input logic [6:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ledger.write_count(value);
  endtask

  task automatic run_mix(input int items, input int alloc_pct);
    logic [PageW-1:0] pg;
    logic [SlotW-1:0] sl;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        send_request(make_req(CmdFree, $urandom_range(0, NumPages - 1),
                              $urandom_range(0, NumSlots - 1)));
      end else if ($urandom_range(0, 99) < alloc_pct || !ledger.pick_held(pg, sl)) begin
        send_request(alloc_req());
      end else begin
        send_request(make_req(CmdFree, pg, sl));
      end
    end
  endtask

  initial begin
    logic [6:0] counts[10];
    ledger = new;
    ledger.reset_state();
    counts = '{7'd64, 7'd1, 7'd3, 7'd127, 7'd0, 7'd8, 7'd65, 7'd5, 7'd2, 7'd42};
    counts[8] = 7'($urandom_range(0, 127));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Free of a closed page, then a double free that still counts, then a close.
    send_request(make_req(CmdFree, 7, 63));
    send_request(alloc_req());
    send_request(alloc_req());
    send_request(make_req(CmdFree, 0, 63));
    send_request(make_req(CmdFree, 0, 1));

    // One slot per page: fill every page, hit full, free out of range, reopen.
    write_slot_count(7'd1);
    repeat (9) send_request(alloc_req());
    send_request(make_req(CmdFree, 3, 1));
    send_request(make_req(CmdFree, 3, 0));
    send_request(alloc_req());

    // A count of zero acts as one, so everything is still full.
    write_slot_count(7'd0);
    send_request(alloc_req());

    // Grow back, then leave the newest page with no free bit below a shrunk count.
    write_slot_count(7'd127);
    send_request(alloc_req());
    send_request(alloc_req());
    send_request(make_req(CmdFree, 3, 40));
    send_request(make_req(CmdFree, 3, 41));
    write_slot_count(7'd2);
    send_request(alloc_req());

    for (int ph = 0; ph < 10; ph++) begin
      write_slot_count(counts[ph]);
      steady = (ph == 3);
      if (ph == 5) hold_off_pending = 1'b1;
      run_mix(150, (ph % 2 == 0) ? 65 : 40);
    end
    steady = 1'b0;
    drain();

    if (ledger.awaited.size() != 0) begin
      ledger.errors++;
      $error("%0d responses never arrived", ledger.awaited.size());
    end
    $display("Run covered %0d allocates (%0d opened a page, %0d hit full) and %0d frees",
             ledger.n_alloc, ledger.n_opened, ledger.n_full, ledger.n_free);
    $display("(%0d closed a page, %0d ignored) over %0d slot counts; %0d responses checked.",
             ledger.n_closed, ledger.n_ignored, ledger.n_settings, ledger.n_checked);
    if (ledger.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: paged_slot_bitmap_allocator_top.f
+incdir+hdl
hdl/psba_pkg.sv
hdl/psba_cell.sv
hdl/paged_slot_bitmap_allocator_top.sv
hdl/psba_checker.sv
tb/testbench.sv
